### rtl/raid0_request_splitter_defines.svh
// Assertion macros shared by the RAID-0 request splitter RTL
`ifndef RAID0_REQUEST_SPLITTER_DEFINES_SVH
`define RAID0_REQUEST_SPLITTER_DEFINES_SVH

`ifndef SYNTHESIS
// Plain property check on the block clock, off while reset is high
`define RRS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("raid0_request_splitter: assertion failed");
// Same-cycle implication
`define RRS_ASSERT_IMP(lbl, ante, cons) \
   `RRS_ASSERT(lbl, (ante) |-> (cons))
// Next-cycle implication
`define RRS_ASSERT_NXT(lbl, ante, cons) \
   `RRS_ASSERT(lbl, (ante) |=> (cons))
`else
`define RRS_ASSERT(lbl, prop)
`define RRS_ASSERT_IMP(lbl, ante, cons)
`define RRS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### rtl/rrs_pkg.sv
// Types and constants of the RAID-0 request splitter
package rrs_pkg;

   // Width of the internal block address; addresses wrap at this width
   localparam int BLOCK_ADDR_BITS = 32;
   // Step counter of the disk divider
   localparam int DIV_CNT_BITS    = $clog2(BLOCK_ADDR_BITS);

   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 16;

   localparam logic [15:0] BPS_RESET = 16'd128;
   localparam logic [7:0]  ND_RESET  = 8'd4;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BLOCKS_PER_STRIDE = 1'b0,
      CSR_NUM_DISKS         = 1'b1
   } csr_index_type;

   // Input transaction: one extent
   typedef struct packed {
      logic [31:0] extent_start;
      logic [15:0] extent_length;
      logic        last_extent;
   } req_type;

   // Output transaction: one piece
   typedef struct packed {
      logic [31:0] piece_start;
      logic [15:0] piece_length;
      logic [7:0]  target_disk;
      logic [15:0] sub_number;
      logic        sub_done;
      logic        request_done;
      logic        too_long;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;          // capture the accepted extent
      logic open_sub;      // open a subrequest, start the disk divider
      logic set_disk;      // take the divider result as the subrequest disk
      logic emit_piece;    // emit one regular piece
      logic emit_special;  // emit the error or empty-close piece
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic too_long;      // extent exceeds 63 strides
      logic len_zero;      // extent has no blocks
      logic last;          // extent closes the request
      logic sub_empty;     // no subrequest open
      logic div_done;      // disk divider finished
      logic out_free;      // output register can take a piece
      logic final_piece;   // current piece uses up the extent
   } status_type;

endpackage

### rtl/raid0_request_splitter.sv
// Top level of the RAID-0 request splitter
//
// Takes a block request one extent per transaction and returns it as RAID-0
// pieces, in order; the request ends with the extent marked last_extent.
// Pieces are grouped into subrequests of up to blocks_per_stride blocks, and
// a subrequest may run across extents. One extent is in work at a time:
// req_ready is high only while the block is idle. An extent is accepted,
// then checked, then split into pieces, one per cycle while the output
// register can take them; each subrequest that it opens first waits for
// its target disk (start block / blocks_per_stride) mod num_disks, which
// comes from a bit-serial divider taking one step per address bit (32 steps).
// An extent longer than 63 strides, or an empty last extent, gives a single
// piece; an empty extent that is not last gives none. A finished piece waits
// in an output register; opening the next subrequest goes on meanwhile, but
// the next piece enters it only at the edge where the waiting one is taken.
// Configuration writes take effect at once and belong to idle periods.

module raid0_request_splitter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  rrs_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rrs_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  rrs_pkg::csr_index_type            csr_index,
   input  logic [rrs_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import rrs_pkg::*;

   cmd_type    cmd;
   status_type status;

   rrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   rrs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

### rtl/rrs_disk_div.sv
// Bit-serial disk selector: (address / blocks_per_stride) mod num_disks
`include "raid0_request_splitter_defines.svh"

module rrs_disk_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [rrs_pkg::BLOCK_ADDR_BITS-1:0] dividend,
   input  logic [15:0]                         divisor,
   input  logic [7:0]                          modulus,
   output logic                                done,
   output logic [7:0]                          disk
);
   import rrs_pkg::*;

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [DIV_CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [BLOCK_ADDR_BITS-1:0] dvd_ff, dvd_in;
   logic [15:0]                rem_ff, rem_in;
   logic [15:0]                dvs_ff, dvs_in;
   logic [7:0]                 mod_ff, mod_in;
   logic [7:0]                 acc_ff, acc_in;

   logic [16:0] trial;
   logic        qbit;
   logic [8:0]  acc_shift;

   // One restoring-division step per cycle; each quotient bit is folded
   // into a running remainder modulo the disk count (MSB first).
   always_comb begin
      trial     = {rem_ff, dvd_ff[BLOCK_ADDR_BITS-1]};
      qbit      = (trial >= {1'b0, dvs_ff});
      acc_shift = {acc_ff, qbit};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      mod_in  = mod_ff;
      acc_in  = acc_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         mod_in  = modulus;
         acc_in  = '0;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         rem_in = qbit ? 16'(trial - {1'b0, dvs_ff}) : trial[15:0];
         acc_in = (acc_shift >= {1'b0, mod_ff}) ? 8'(acc_shift - {1'b0, mod_ff})
                                                 : acc_shift[7:0];
         cnt_in = cnt_ff + DIV_CNT_BITS'(1);
         if (cnt_ff == DIV_CNT_BITS'(BLOCK_ADDR_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      mod_ff <= mod_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign disk = acc_ff;

   // A new division never starts on top of a running one
   `RRS_ASSERT_IMP(a_div_start_idle, start, !busy_ff)
   // The result pulse comes only right after the last step
   `RRS_ASSERT_IMP(a_div_done_after_busy, done_ff, $past(busy_ff) && !busy_ff)

endmodule

### rtl/rrs_datapath.sv
// Datapath: configuration, extent and subrequest state, piece output register
`include "raid0_request_splitter_defines.svh"

module rrs_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  rrs_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output rrs_pkg::rsp_type            rsp_data,
   input  logic                        csr_we,
   input  rrs_pkg::csr_index_type      csr_index,
   input  logic [rrs_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   input  rrs_pkg::cmd_type            cmd,
   output rrs_pkg::status_type         status
);
   import rrs_pkg::*;

   logic [15:0]                bps_ff, bps_in;
   logic [7:0]                 nd_ff, nd_in;
   logic [BLOCK_ADDR_BITS-1:0] addr_ff, addr_in;
   logic [15:0]                left_ff, left_in;
   logic                       last_ff, last_in;
   logic [15:0]                sub_left_ff, sub_left_in;
   logic [7:0]                 sub_disk_ff, sub_disk_in;
   logic [15:0]                sub_cnt_ff, sub_cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff, rsp_data_in;

   logic [15:0] bps_eff;
   logic [7:0]  nd_eff;
   logic [21:0] stride_limit;
   logic        too_long;
   logic [15:0] len;
   logic [15:0] left_next;
   logic [15:0] sub_next;
   logic        rdone;
   logic        sdone;
   logic        div_done;
   logic [7:0]  div_disk;

   // Zero registers act as one
   assign bps_eff = (bps_ff == '0) ? 16'd1 : bps_ff;
   assign nd_eff  = (nd_ff == '0) ? 8'd1 : nd_ff;

   // 63 strides = 64 * bps - bps
   assign stride_limit = {bps_eff, 6'b0} - {6'b0, bps_eff};
   assign too_long     = ({6'b0, left_ff} > stride_limit);

   // Current piece: bounded by what is left of the extent and the subrequest
   assign len       = (left_ff < sub_left_ff) ? left_ff : sub_left_ff;
   assign left_next = left_ff - len;
   assign sub_next  = sub_left_ff - len;
   assign rdone     = last_ff && (left_next == '0);
   assign sdone     = rdone || (sub_next == '0);

   rrs_disk_div u_disk_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.open_sub),
      .dividend (addr_ff),
      .divisor  (bps_eff),
      .modulus  (nd_eff),
      .done     (div_done),
      .disk     (div_disk)
   );

   // Next-state logic
   always_comb begin
      bps_in       = bps_ff;
      nd_in        = nd_ff;
      addr_in      = addr_ff;
      left_in      = left_ff;
      last_in      = last_ff;
      sub_left_in  = sub_left_ff;
      sub_disk_in  = sub_disk_ff;
      sub_cnt_in   = sub_cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // Configuration writes
      if (csr_we) begin
         case (csr_index)
            CSR_BLOCKS_PER_STRIDE: bps_in = csr_wdata[15:0];
            CSR_NUM_DISKS:         nd_in  = csr_wdata[7:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         addr_in = BLOCK_ADDR_BITS'(req_data.extent_start);
         left_in = req_data.extent_length;
         last_in = req_data.last_extent;
      end

      if (cmd.open_sub) begin
         sub_left_in = bps_eff;
      end

      if (cmd.set_disk) begin
         sub_disk_in = div_disk;
      end

      // Regular piece
      if (cmd.emit_piece) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.piece_start   = 32'(addr_ff);
         rsp_data_in.piece_length  = len;
         rsp_data_in.target_disk   = sub_disk_ff;
         rsp_data_in.sub_number    = sub_cnt_ff;
         rsp_data_in.sub_done      = sdone;
         rsp_data_in.request_done  = rdone;
         rsp_data_in.too_long      = 1'b0;
         addr_in                   = addr_ff + BLOCK_ADDR_BITS'(len);
         left_in                   = left_next;
         if (rdone) begin
            sub_left_in = '0;
            sub_cnt_in  = '0;
         end else begin
            sub_left_in = sub_next;
            if (sub_next == '0) begin
               sub_cnt_in = sub_cnt_ff + 16'd1;
            end
         end
      end

      // Error piece, or the empty closing piece of a request
      if (cmd.emit_special) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.piece_start   = 32'(addr_ff);
         rsp_data_in.piece_length  = '0;
         rsp_data_in.target_disk   = sub_disk_ff;
         rsp_data_in.sub_number    = sub_cnt_ff;
         rsp_data_in.sub_done      = last_ff;
         rsp_data_in.request_done  = last_ff;
         rsp_data_in.too_long      = too_long;
         if (last_ff) begin
            sub_left_in = '0;
            sub_cnt_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff       <= BPS_RESET;
         nd_ff        <= ND_RESET;
         sub_left_ff  <= '0;
         sub_disk_ff  <= '0;
         sub_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bps_ff       <= bps_in;
         nd_ff        <= nd_in;
         sub_left_ff  <= sub_left_in;
         sub_disk_ff  <= sub_disk_in;
         sub_cnt_ff   <= sub_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff     <= addr_in;
      left_ff     <= left_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Status to the controller
   always_comb begin
      status.too_long    = too_long;
      status.len_zero    = (left_ff == '0);
      status.last        = last_ff;
      status.sub_empty   = (sub_left_ff == '0);
      status.div_done    = div_done;
      status.out_free    = !rsp_valid_ff || rsp_ready;
      status.final_piece = (left_next == '0);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A regular piece always carries blocks from an open subrequest
   `RRS_ASSERT_IMP(a_piece_nonempty, cmd.emit_piece,
                   (len != '0) && (sub_left_ff != '0))
   // Nothing is loaded into the output register while it still holds a piece
   `RRS_ASSERT_IMP(a_no_overwrite, cmd.emit_piece || cmd.emit_special,
                   !rsp_valid_ff || rsp_ready)

endmodule

### rtl/rrs_ctrl.sv
// Controller: sequences extent check, subrequest opening and piece emission
`include "raid0_request_splitter_defines.svh"

module rrs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output rrs_pkg::cmd_type    cmd,
   input  rrs_pkg::status_type status
);
   import rrs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SPECIAL,
      ST_DIV,
      ST_PIECE
   } state_type;

   state_type state_ff, state_in;

   // Commands and next state
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.too_long) begin
               state_in = ST_SPECIAL;
            end else if (status.len_zero) begin
               state_in = status.last ? ST_SPECIAL : ST_IDLE;
            end else begin
               state_in = ST_PIECE;
            end
         end
         ST_SPECIAL: begin
            if (status.out_free) begin
               cmd.emit_special = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.set_disk = 1'b1;
               state_in     = ST_PIECE;
            end
         end
         ST_PIECE: begin
            if (status.sub_empty) begin
               cmd.open_sub = 1'b1;
               state_in     = ST_DIV;
            end else if (status.out_free) begin
               cmd.emit_piece = 1'b1;
               if (status.final_piece) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // The disk must be known before any piece of a new subrequest goes out
   `RRS_ASSERT_NXT(a_open_then_div, cmd.open_sub, state_ff == ST_DIV)

endmodule
